### rtl/kcv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_pkg
// Shared types and constants for the constant-velocity point tracker.
// ----------------------------------------------------------------------------
package kcv_pkg;

    localparam int COV_W = 32;   // covariance register width
    localparam int REG_W = 31;   // noise and covariance setting width
    localparam int IDX_W = 2;    // register index width

    localparam logic [IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE      = 2'd1;
    localparam logic [IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

    localparam logic [REG_W-1:0] RST_PROCESS_NOISE      = 31'd1678;
    localparam logic [REG_W-1:0] RST_MEASURE_NOISE      = 31'd167772160;
    localparam logic [REG_W-1:0] RST_INITIAL_COVARIANCE = 31'd1677722;

    typedef struct packed {
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
    } t_out_word;

    // Control from the sequencer to each axis lane.
    typedef struct packed {
        logic start;   // run one predict and correct pass
        logic arm;     // clear position and velocity
    } t_lane_ctl;

endpackage
`default_nettype wire

### rtl/kcv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_div
// Radix-2 restoring divider for the gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcv_div import kcv_pkg::*; #(
    parameter int FRAC = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [COV_W-1:0] i_num,
    input  wire logic [COV_W:0]   i_den,
    output logic      [FRAC:0]    o_quot,
    output logic                  o_done
);

    localparam int KW = FRAC + 1;
    localparam int CW = $clog2(KW + 1);
    localparam int RW = COV_W + 2;

    logic [RW-1:0]  r_rem;
    logic [COV_W:0] r_den;
    logic [KW-1:0]  r_quot;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_zero;
    logic           r_done;

    logic          ge;
    logic [RW-1:0] rem_sub;

    // The numerator never exceeds the divisor, so the quotient fits FRAC+1 bits.
    assign ge      = r_rem >= RW'(r_den);
    assign rem_sub = ge ? r_rem - RW'(r_den) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(KW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= RW'(i_num);
            r_den  <= i_den;
            r_zero <= (i_den == '0);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {rem_sub[RW-2:0], 1'b0};
            r_quot <= {r_quot[KW-2:0], ge};
        end
    end

    // A zero divisor gives a zero gain.
    assign o_quot = r_zero ? '0 : r_quot;
    assign o_done = r_done;

endmodule
`default_nettype wire

### rtl/kcv_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_lane
// One axis of the tracker: holds position and velocity and applies both gains.
// ----------------------------------------------------------------------------
module kcv_lane import kcv_pkg::*; #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_lane_ctl                    i_ctl,
    input  wire logic signed [31:0]           i_meas,
    input  wire logic [COV_FRAC_BITS:0]       i_k0,
    input  wire logic [COV_FRAC_BITS:0]       i_k1,
    output logic signed [DATA_WIDTH-1:0]      o_pos,
    output logic                              o_done
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = COV_FRAC_BITS;
    localparam int KW = F + 1;
    localparam int EW = ((DW > 32) ? DW : 32) + 1;
    localparam int HW = EW - 32;
    localparam int PW = KW + 32;
    localparam int AW = EW + 1;
    localparam int SW = AW + 1;

    localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);
    localparam logic signed [DW-1:0] D_HI = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] D_LO = {1'b1, {(DW - 1){1'b0}}};
    localparam logic signed [SW-1:0] S_HI = SW'(D_HI);
    localparam logic signed [SW-1:0] S_LO = SW'(D_LO);

    logic signed [DW-1:0] r_pos, r_vel, r_pre;
    logic signed [31:0]   r_z;
    logic [EW-1:0]        r_mag;
    logic                 r_neg;
    logic [PW-1:0]        r_prod;
    logic [AW-1:0]        r_acc0, r_acc1;
    logic [2:0]           r_step;
    logic                 r_busy;
    logic                 r_done;

    logic signed [DW:0]   pv_sum;
    logic signed [DW-1:0] pre_sat;
    logic signed [EW-1:0] err;
    logic [KW-1:0]        mul_k;
    logic [31:0]          mul_op;
    logic [AW-1:0]        lo_part, hi_part;
    logic signed [SW-1:0] acc0_s, acc1_s, pos_sum, vel_sum;
    logic signed [DW-1:0] pos_sat, vel_sat;

    assign pv_sum  = (DW + 1)'(r_pos) + (DW + 1)'(r_vel);
    assign pre_sat = (pv_sum[DW] != pv_sum[DW-1]) ? (pv_sum[DW] ? D_LO : D_HI)
                                                 : pv_sum[DW-1:0];
    assign err     = EW'(r_z) - EW'(r_pre);

    // Steps 2 and 3 use K0, steps 4 and 5 use K1; even steps take the low word.
    assign mul_k   = (r_step == 3'd2 || r_step == 3'd3) ? i_k0 : i_k1;
    assign mul_op  = r_step[0] ? 32'(r_mag[EW-1:32]) : r_mag[31:0];
    assign lo_part = AW'(((PW + 1)'(r_prod) + HALF) >> F);
    assign hi_part = AW'(r_prod) << (32 - F);

    assign acc0_s  = r_neg ? -SW'({1'b0, r_acc0}) : SW'({1'b0, r_acc0});
    assign acc1_s  = r_neg ? -SW'({1'b0, r_acc1}) : SW'({1'b0, r_acc1});
    assign pos_sum = SW'(r_pre) + acc0_s;
    assign vel_sum = SW'(r_vel) + acc1_s;
    assign pos_sat = (pos_sum > S_HI) ? D_HI : (pos_sum < S_LO) ? D_LO : DW'(pos_sum);
    assign vel_sat = (vel_sum > S_HI) ? D_HI : (vel_sum < S_LO) ? D_LO : DW'(vel_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_pos  <= '0;
            r_vel  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.arm) begin
                r_pos <= '0;
                r_vel <= '0;
            end else if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd1;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 3'd7) begin
                    r_pos  <= pos_sat;
                    r_vel  <= vel_sat;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_pre <= pre_sat;
            r_z   <= i_meas;
        end
        if (r_busy) begin
            case (r_step)
                3'd1: begin
                    r_neg <= err[EW-1];
                    r_mag <= err[EW-1] ? EW'(-err) : EW'(err);
                end
                3'd2: r_prod <= PW'(mul_k) * PW'(mul_op);
                3'd3: begin
                    r_acc0 <= lo_part;
                    r_prod <= PW'(mul_k) * PW'(mul_op);
                end
                3'd4: begin
                    r_acc0 <= r_acc0 + hi_part;
                    r_prod <= PW'(mul_k) * PW'(mul_op);
                end
                3'd5: begin
                    r_acc1 <= lo_part;
                    r_prod <= PW'(mul_k) * PW'(mul_op);
                end
                3'd6: r_acc1 <= r_acc1 + hi_part;
                default: ;
            endcase
        end
    end

    assign o_pos  = r_pos;
    assign o_done = r_done;

endmodule
`default_nettype wire

### rtl/kalman_cv_point_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_cv_point_tracker_unit
// Two-axis constant-velocity Kalman tracker with a shared 2x2 covariance.
// ----------------------------------------------------------------------------
// Words: an arming word gives no result, and every later word gives a result word.
// Flow: one word at a time passes the sequencer and the bit-serial gain dividers;
//   the output register lets the next word in while a result waits.
// Reset: synchronous, active low; clears the armed flag, the lanes and the output
//   valid flag, and restores the three noise and covariance settings.
module kalman_cv_point_tracker_unit import kcv_pkg::*; #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_word             o_out_word,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = COV_FRAC_BITS;
    localparam int KW = F + 1;
    localparam int PW = KW + COV_W;
    localparam int XW = (DW > 32) ? DW : 32;

    localparam logic [PW:0]     HALF  = (PW + 1)'(1) << (F - 1);
    localparam logic [KW-1:0]   K_ONE = KW'(1) << F;
    localparam logic signed [XW-1:0] O_HI = XW'(32'sh7fffffff);
    localparam logic signed [XW-1:0] O_LO = XW'(32'sh80000000);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRED   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_LANE   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // Settings.
    logic [REG_W-1:0] r_q, r_r, r_p0;

    // Sequencer and shared covariance state.
    logic [2:0]       r_state;
    logic             r_armed;
    t_in_word         r_meas;
    logic [COV_W-1:0] r_cpp, r_cpv, r_cvv;
    logic [COV_W-1:0] r_ap, r_bp, r_cp;
    logic [COV_W:0]   r_s;
    logic [KW-1:0]    r_k0, r_k1;
    logic [PW-1:0]    r_prod_a, r_prod_b, r_prod_c;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out_word;

    logic             in_acc;
    logic             out_load;
    logic [COV_W+2:0] ap_sum;
    logic [COV_W:0]   bp_sum, cp_sum;
    logic [COV_W:0]   sc_a, sc_b, sc_c;
    t_lane_ctl        lane_ctl;
    logic             div_start;
    logic [KW-1:0]    k0_q, k1_q;
    logic             div0_done, div1_done;
    logic signed [DW-1:0] pos_x, pos_y;
    logic             lane_x_done, lane_y_done;

    function automatic logic signed [31:0] sat_out(input logic signed [DW-1:0] p);
        logic signed [XW-1:0] w;
        w = XW'(p);
        if (w > O_HI) return 32'sh7fffffff;
        if (w < O_LO) return 32'sh80000000;
        return 32'(w);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Predicted covariance: a+2b+c+q, b+c and c+q, each clipped to 32 bits.
    assign ap_sum = (COV_W + 3)'(r_cpp) + (COV_W + 3)'({r_cpv, 1'b0})
                  + (COV_W + 3)'(r_cvv) + (COV_W + 3)'(r_q);
    assign bp_sum = (COV_W + 1)'(r_cpv) + (COV_W + 1)'(r_cvv);
    assign cp_sum = (COV_W + 1)'(r_cvv) + (COV_W + 1)'(r_q);

    // Rounded gain products for the covariance correction.
    assign sc_a = (COV_W + 1)'(((PW + 1)'(r_prod_a) + HALF) >> F);
    assign sc_b = (COV_W + 1)'(((PW + 1)'(r_prod_b) + HALF) >> F);
    assign sc_c = (COV_W + 1)'(((PW + 1)'(r_prod_c) + HALF) >> F);

    assign lane_ctl  = '{start: (r_state == S_UPD), arm: (in_acc && !r_armed)};
    assign div_start = (r_state == S_DSTART);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q  <= RST_PROCESS_NOISE;
            r_r  <= RST_MEASURE_NOISE;
            r_p0 <= RST_INITIAL_COVARIANCE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PROCESS_NOISE:      r_q  <= i_cfg_data;
                REG_MEASURE_NOISE:      r_r  <= i_cfg_data;
                REG_INITIAL_COVARIANCE: r_p0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: predict, divide for both gains, correct the covariance, then
    // let the two axis lanes apply the gains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_armed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!r_armed) begin
                            r_armed <= 1'b1;
                        end else begin
                            r_state <= S_PRED;
                        end
                    end
                end
                S_PRED:   r_state <= S_DSTART;
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (div0_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:    r_state <= S_UPD;
                S_UPD:    r_state <= S_LANE;
                S_LANE: begin
                    if (lane_x_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_meas <= i_in_word;
            if (!r_armed) begin
                r_cpp <= COV_W'(r_p0);
                r_cpv <= '0;
                r_cvv <= COV_W'(r_p0);
            end
        end
        if (r_state == S_PRED) begin
            r_ap <= (ap_sum[COV_W+2:COV_W] != '0) ? '1 : ap_sum[COV_W-1:0];
            r_bp <= bp_sum[COV_W] ? '1 : bp_sum[COV_W-1:0];
            r_cp <= cp_sum[COV_W] ? '1 : cp_sum[COV_W-1:0];
            r_s  <= ((ap_sum[COV_W+2:COV_W] != '0) ? (COV_W + 1)'({COV_W{1'b1}})
                                                   : (COV_W + 1)'(ap_sum[COV_W-1:0]))
                  + (COV_W + 1)'(r_r);
        end
        if (div0_done) begin
            r_k0 <= k0_q;
            r_k1 <= k1_q;
        end
        if (r_state == S_MUL) begin
            r_prod_a <= PW'(r_k0) * PW'(r_ap);
            r_prod_b <= PW'(r_k0) * PW'(r_bp);
            r_prod_c <= PW'(r_k1) * PW'(r_bp);
        end
        if (r_state == S_UPD) begin
            r_cpp <= (sc_a > (COV_W + 1)'(r_ap)) ? '0 : COV_W'((COV_W + 1)'(r_ap) - sc_a);
            r_cpv <= (sc_b > (COV_W + 1)'(r_bp)) ? '0 : COV_W'((COV_W + 1)'(r_bp) - sc_b);
            r_cvv <= (sc_c > (COV_W + 1)'(r_cp)) ? '0 : COV_W'((COV_W + 1)'(r_cp) - sc_c);
        end
    end

    // Gain dividers: K0 = a'/S and K1 = b'/S run side by side.
    kcv_div #(.FRAC(F)) u_div_k0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_ap),
        .i_den   (r_s),
        .o_quot  (k0_q),
        .o_done  (div0_done)
    );

    kcv_div #(.FRAC(F)) u_div_k1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_bp),
        .i_den   (r_s),
        .o_quot  (k1_q),
        .o_done  (div1_done)
    );

    // One lane per axis.
    kcv_lane #(.DATA_WIDTH(DW), .COV_FRAC_BITS(F)) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_meas  (r_meas.meas_x),
        .i_k0    (r_k0),
        .i_k1    (r_k1),
        .o_pos   (pos_x),
        .o_done  (lane_x_done)
    );

    kcv_lane #(.DATA_WIDTH(DW), .COV_FRAC_BITS(F)) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_meas  (r_meas.meas_y),
        .i_k0    (r_k0),
        .i_k1    (r_k1),
        .o_pos   (pos_y),
        .o_done  (lane_y_done)
    );

    // Merge stage: both lane positions go into the output register together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.est_x <= sat_out(pos_x);
            r_out_word.est_y <= sat_out(pos_y);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // Both dividers and both lanes run in lockstep.
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div0_done == div1_done) && (lane_x_done == lane_y_done))
        else $error("gain dividers or axis lanes out of step");

    // A gain never exceeds one.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_k0 <= K_ONE) && (r_k1 <= K_ONE))
        else $error("Kalman gain above one");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall)
        |=> (r_out_valid && $stable(r_out_word)))
        else $error("result word overwritten while stalled");

    // Lanes finish only while the sequencer waits on them.
    a_lane_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_x_done |-> (r_state == S_LANE))
        else $error("lane finished outside its slot");
`endif

endmodule
`default_nettype wire
